>>> rtl/ltpt_pkg.sv
`default_nettype none

package ltpt_pkg;

  // Number of loop slots and width of a stored sample index.
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = 24;

  // Fixed widths of the port fields.
  localparam int FIELD_W   = 24;
  localparam int FRAMES_W  = 13;
  localparam int SEL_W     = 3;

  // Slot index width and the wider of the two position widths for compares.
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W     = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0]   IDX_MASK   = '1;
  localparam logic [FIELD_W-1:0] LIMIT_RST  = '1;

  typedef enum logic [1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_SET_CTRL = 2'd1,
    REQ_WRITE_SLOT = 2'd2,
    REQ_READ_SLOT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_PASSTHROUGH = 2'd0,
    MODE_PLAYBACK = 2'd1,
    MODE_RECORDING = 2'd2,
    MODE_OVERDUBBING = 2'd3
  } mode_e;

  // One classified command as it sits in the queue.
  typedef struct packed {
    req_e              req;
    logic [FRAMES_W-1:0] frames;
    mode_e             mode;
    logic [SEL_W-1:0]  selected;
    logic [SEL_W-1:0]  slot;
    logic              slot_ok;
    logic              active;
    logic              rpt;
    logic [IDX_W-1:0]  pos_cur;
    logic [IDX_W-1:0]  pos_start;
    logic [IDX_W-1:0]  pos_end;
    logic [IDX_W-1:0]  mlen;
    logic [IDX_W-1:0]  mpos;
  } cmd_t;

  // One result as presented on the output ports.
  typedef struct packed {
    logic [FIELD_W-1:0] cur;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] fin;
    logic               active;
    logic               rpt;
    logic [FIELD_W-1:0] master_pos;
    logic [FIELD_W-1:0] master_len;
    logic [1:0]         mode;
    logic               full;
  } res_t;

  // The limit in use: the configured limit, capped at the largest index.
  function automatic logic [IDX_W-1:0] eff_limit(input logic [FIELD_W-1:0] lim);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(lim);
    if (wide > CMP_W'(IDX_MASK)) begin
      return IDX_MASK;
    end
    return IDX_W'(wide);
  endfunction

  // True when a slot number names an existing slot.
  function automatic logic slot_in_range(input logic [SEL_W-1:0] sel);
    return int'(sel) < NUM_SLOTS;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ltpt_queue.sv
`default_nettype none

module ltpt_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ltpt_pkg::cmd_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output ltpt_pkg::cmd_t       pop_data_o,
  output logic                 empty_o
);

  ltpt_pkg::cmd_t                    mem_q [ltpt_pkg::QUEUE_DEPTH];
  logic [ltpt_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ltpt_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ltpt_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o     = (cnt_q == ltpt_pkg::QCNT_W'(ltpt_pkg::QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + ltpt_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + ltpt_pkg::QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + ltpt_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - ltpt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ltpt_front.sv
`default_nettype none

module ltpt_front (
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [ltpt_pkg::FRAMES_W-1:0]     frames_i,
  input  wire logic [1:0]                        mode_in_i,
  input  wire logic [ltpt_pkg::SEL_W-1:0]        selected_in_i,
  input  wire logic [ltpt_pkg::SEL_W-1:0]        slot_sel_i,
  input  wire logic                              active_in_i,
  input  wire logic                              repeat_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0]      cur_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0]      start_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0]      end_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0]      master_len_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0]      master_pos_in_i,
  input  wire logic                              queue_full_i,
  output logic                                   push_o,
  output ltpt_pkg::cmd_t                         cmd_o
);

  // A request is taken whenever the queue has room.
  assign busy   = queue_full_i;
  assign push_o = start && !queue_full_i;

  // Decode the request and fit every position to the stored index width.
  always_comb begin
    cmd_o.req       = ltpt_pkg::req_e'(req_type_i);
    cmd_o.frames    = frames_i;
    cmd_o.mode      = ltpt_pkg::mode_e'(mode_in_i);
    cmd_o.selected  = selected_in_i;
    cmd_o.slot      = slot_sel_i;
    cmd_o.slot_ok   = ltpt_pkg::slot_in_range(slot_sel_i);
    cmd_o.active    = active_in_i;
    cmd_o.rpt       = repeat_in_i;
    cmd_o.pos_cur   = ltpt_pkg::IDX_W'(cur_in_i);
    cmd_o.pos_start = ltpt_pkg::IDX_W'(start_in_i);
    cmd_o.pos_end   = ltpt_pkg::IDX_W'(end_in_i);
    cmd_o.mlen      = ltpt_pkg::IDX_W'(master_len_in_i);
    cmd_o.mpos      = ltpt_pkg::IDX_W'(master_pos_in_i);
  end

endmodule

`default_nettype wire

>>> rtl/ltpt_back.sv
`default_nettype none

module ltpt_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ltpt_pkg::FIELD_W-1:0] cfg_data_i,
  input  wire logic                         queue_empty_i,
  input  wire ltpt_pkg::cmd_t               head_i,
  output logic                              pop_o,
  output logic                              res_valid_o,
  output ltpt_pkg::res_t                    res_o
);

  localparam int IW = ltpt_pkg::IDX_W;
  localparam int SW = ltpt_pkg::SLOT_W;
  localparam int NS = ltpt_pkg::NUM_SLOTS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MASTER,
    ST_WALK,
    ST_FINISH,
    ST_SHOW
  } state_e;

  state_e                         state_q, state_d;
  logic [ltpt_pkg::FIELD_W-1:0]   limit_q, limit_d;
  logic [IW-1:0]                  cur_q [NS];
  logic [IW-1:0]                  cur_d [NS];
  logic [IW-1:0]                  start_q [NS];
  logic [IW-1:0]                  start_d [NS];
  logic [IW-1:0]                  end_q [NS];
  logic [IW-1:0]                  end_d [NS];
  logic [NS-1:0]                  active_q, active_d;
  logic [NS-1:0]                  rpt_q, rpt_d;
  logic [IW-1:0]                  mpos_q, mpos_d;
  logic [IW-1:0]                  mlen_q, mlen_d;
  ltpt_pkg::mode_e                mode_q, mode_d;
  logic [ltpt_pkg::SEL_W-1:0]     sel_q, sel_d;
  logic [ltpt_pkg::FRAMES_W-1:0]  frames_q, frames_d;
  logic [SW-1:0]                  idx_q, idx_d;
  logic [ltpt_pkg::SEL_W-1:0]     show_q, show_d;
  logic                           full_q, full_d;
  logic                           res_valid_q, res_valid_d;
  ltpt_pkg::res_t                 res_q, res_d;

  logic [IW-1:0]                  lim;
  logic [IW:0]                    sum;
  logic [IW:0]                    msum;
  logic [IW-1:0]                  pos;
  logic [IW-1:0]                  new_end;
  logic                           recording;
  logic                           show_ok;
  logic [SW-1:0]                  show_idx;
  logic [SW-1:0]                  wr_idx;

  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign lim         = ltpt_pkg::eff_limit(limit_q);
  assign show_ok     = ltpt_pkg::slot_in_range(show_q);
  assign show_idx    = SW'(show_q);
  assign wr_idx      = SW'(head_i.slot);

  // Sequencer: take a command, walk the slots for an advance outside passthrough, then report.
  always_comb begin
    state_d     = state_q;
    limit_d     = cfg_valid_i ? cfg_data_i : limit_q;
    cur_d       = cur_q;
    start_d     = start_q;
    end_d       = end_q;
    active_d    = active_q;
    rpt_d       = rpt_q;
    mpos_d      = mpos_q;
    mlen_d      = mlen_q;
    mode_d      = mode_q;
    sel_d       = sel_q;
    frames_d    = frames_q;
    idx_d       = idx_q;
    show_d      = show_q;
    full_d      = full_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    sum         = '0;
    msum        = '0;
    pos         = '0;
    new_end     = '0;
    recording   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i) begin
          pop_o    = 1'b1;
          full_d   = 1'b0;
          frames_d = head_i.frames;
          idx_d    = '0;
          state_d  = ST_SHOW;
          case (head_i.req)
            ltpt_pkg::REQ_ADVANCE: begin
              show_d = sel_q;
              if (mode_q != ltpt_pkg::MODE_PASSTHROUGH) begin
                state_d = ST_MASTER;
              end
            end
            ltpt_pkg::REQ_SET_CTRL: begin
              mode_d = head_i.mode;
              sel_d  = head_i.selected;
              mlen_d = head_i.mlen;
              mpos_d = head_i.mpos;
              show_d = head_i.selected;
            end
            ltpt_pkg::REQ_WRITE_SLOT: begin
              show_d = head_i.slot;
              if (head_i.slot_ok) begin
                active_d[wr_idx] = head_i.active;
                rpt_d[wr_idx]    = head_i.rpt;
                cur_d[wr_idx]    = head_i.pos_cur;
                start_d[wr_idx]  = head_i.pos_start;
                end_d[wr_idx]    = head_i.pos_end;
              end
            end
            default: begin
              show_d = head_i.slot;
            end
          endcase
        end
      end

      // Master position moves first and saturates at the limit.
      ST_MASTER: begin
        msum    = {1'b0, mpos_q} + (IW+1)'(frames_q);
        mpos_d  = (msum > (IW+1)'(lim)) ? lim : IW'(msum);
        state_d = ST_WALK;
      end

      // One slot a cycle.
      ST_WALK: begin
        if (active_q[idx_q]) begin
          sum       = {1'b0, cur_q[idx_q]} + (IW+1)'(frames_q);
          recording = (int'(sel_q) == int'(idx_q)) &&
                      ((mode_q == ltpt_pkg::MODE_RECORDING) ||
                       (mode_q == ltpt_pkg::MODE_OVERDUBBING));
          if (recording) begin
            if (sum > (IW+1)'(lim)) begin
              pos    = lim;
              mode_d = ltpt_pkg::MODE_PLAYBACK;
              full_d = 1'b1;
            end else begin
              pos = IW'(sum);
            end
            new_end       = (pos > end_q[idx_q]) ? pos : end_q[idx_q];
            cur_d[idx_q]  = pos;
            end_d[idx_q]  = new_end;
            if (new_end > mlen_q) begin
              mlen_d = new_end;
            end
          end else begin
            pos = sum[IW] ? ltpt_pkg::IDX_MASK : IW'(sum);
            if (rpt_q[idx_q] && (pos > end_q[idx_q])) begin
              pos = start_q[idx_q];
            end
            if (mpos_q > mlen_q) begin
              pos = rpt_q[idx_q] ? start_q[idx_q] : '0;
            end
            cur_d[idx_q] = pos;
          end
        end
        if (idx_q == SW'(NS - 1)) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end

      // In playback the master restarts once it passes its length.
      ST_FINISH: begin
        if ((mode_q == ltpt_pkg::MODE_PLAYBACK) && (mpos_q > mlen_q)) begin
          mpos_d = '0;
        end
        state_d = ST_SHOW;
      end

      // Present the reported slot and the master fields for one cycle.
      ST_SHOW: begin
        res_valid_d    = 1'b1;
        res_d.cur      = show_ok ? ltpt_pkg::FIELD_W'(cur_q[show_idx]) : '0;
        res_d.start    = show_ok ? ltpt_pkg::FIELD_W'(start_q[show_idx]) : '0;
        res_d.fin      = show_ok ? ltpt_pkg::FIELD_W'(end_q[show_idx]) : '0;
        res_d.active   = show_ok && active_q[show_idx];
        res_d.rpt      = show_ok && rpt_q[show_idx];
        res_d.master_pos = ltpt_pkg::FIELD_W'(mpos_q);
        res_d.master_len = ltpt_pkg::FIELD_W'(mlen_q);
        res_d.mode     = mode_q;
        res_d.full     = full_q;
        state_d        = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= ltpt_pkg::LIMIT_RST;
      for (int i = 0; i < NS; i++) begin
        cur_q[i]   <= '0;
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
      active_q    <= '0;
      rpt_q       <= '0;
      mpos_q      <= '0;
      mlen_q      <= '0;
      mode_q      <= ltpt_pkg::MODE_PASSTHROUGH;
      sel_q       <= '0;
      frames_q    <= '0;
      idx_q       <= '0;
      show_q      <= '0;
      full_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      cur_q       <= cur_d;
      start_q     <= start_d;
      end_q       <= end_d;
      active_q    <= active_d;
      rpt_q       <= rpt_d;
      mpos_q      <= mpos_d;
      mlen_q      <= mlen_d;
      mode_q      <= mode_d;
      sel_q       <= sel_d;
      frames_q    <= frames_d;
      idx_q       <= idx_d;
      show_q      <= show_d;
      full_q      <= full_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/loop_track_position_tracker_unit.sv
// Loop track position tracker.
// Requests are offered on start with their fields; a request is taken at a
// rising edge where start is high and busy is low. Requests land in a
// two-entry command queue, so busy rises only when that queue is full.
// Every request gives exactly one result, shown for one cycle with
// result_valid_o high; the receiver cannot hold results off.
// For set control, write slot, read slot and an advance in passthrough mode,
// the sequencer goes from idle straight to the result state; any other
// advance passes through the master, walk and finish states first, the walk
// updating one slot per cycle. Results leave in request
// order; the queue lets the next requests be taken while one is at work.
// The sequencer works on one command at a time and takes the next from the
// queue only after the result of the last has been shown.
// The sample limit is written through cfg_valid_i / cfg_data_i; cfg_ready_o
// is always high and each transfer is written into the limit register.
// Reset clears all slots, the master position and length, selects slot 0,
// sets passthrough mode, empties the queue and sets the limit to all ones.
`default_nettype none

module loop_track_position_tracker_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [ltpt_pkg::FRAMES_W-1:0] frames_i,
  input  wire logic [1:0]                   mode_in_i,
  input  wire logic [ltpt_pkg::SEL_W-1:0]   selected_in_i,
  input  wire logic [ltpt_pkg::SEL_W-1:0]   slot_sel_i,
  input  wire logic                         active_in_i,
  input  wire logic                         repeat_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0] cur_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0] start_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0] end_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0] master_len_in_i,
  input  wire logic [ltpt_pkg::FIELD_W-1:0] master_pos_in_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ltpt_pkg::FIELD_W-1:0] cfg_data_i,
  output logic                              result_valid_o,
  output logic [ltpt_pkg::FIELD_W-1:0]      cur_out_o,
  output logic [ltpt_pkg::FIELD_W-1:0]      start_out_o,
  output logic [ltpt_pkg::FIELD_W-1:0]      end_out_o,
  output logic                              active_out_o,
  output logic                              repeat_out_o,
  output logic [ltpt_pkg::FIELD_W-1:0]      master_pos_out_o,
  output logic [ltpt_pkg::FIELD_W-1:0]      master_len_out_o,
  output logic [1:0]                        mode_out_o,
  output logic                              buffer_full_o
);

  ltpt_pkg::cmd_t push_cmd;
  ltpt_pkg::cmd_t head_cmd;
  ltpt_pkg::res_t res;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Request decode and acceptance.
  ltpt_front u_front (
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .frames_i        (frames_i),
    .mode_in_i       (mode_in_i),
    .selected_in_i   (selected_in_i),
    .slot_sel_i      (slot_sel_i),
    .active_in_i     (active_in_i),
    .repeat_in_i     (repeat_in_i),
    .cur_in_i        (cur_in_i),
    .start_in_i      (start_in_i),
    .end_in_i        (end_in_i),
    .master_len_in_i (master_len_in_i),
    .master_pos_in_i (master_pos_in_i),
    .queue_full_i    (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Command queue between decode and execution.
  ltpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (q_empty)
  );

  // Slot state and the sequencer that updates it.
  ltpt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .queue_empty_i (q_empty),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .res_valid_o   (result_valid_o),
    .res_o         (res)
  );

  // Result fields onto their ports.
  assign cur_out_o        = res.cur;
  assign start_out_o      = res.start;
  assign end_out_o        = res.fin;
  assign active_out_o     = res.active;
  assign repeat_out_o     = res.rpt;
  assign master_pos_out_o = res.master_pos;
  assign master_len_out_o = res.master_len;
  assign mode_out_o       = res.mode;
  assign buffer_full_o    = res.full;

endmodule

`default_nettype wire

>>> tb/tb_loop_track_position_tracker_unit.sv
`timescale 1ns / 1ps

module tb_loop_track_position_tracker_unit;
  import ltpt_pkg::*;

  // Cycles to let pass once nothing is outstanding.
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 185;

  // One request as the sender offers it.
  typedef struct {
    req_e        kind;
    logic [12:0] frames;
    mode_e       mode;
    logic [2:0]  selected;
    logic [2:0]  slot;
    logic        active;
    logic        rpt;
    logic [23:0] pos_cur;
    logic [23:0] pos_start;
    logic [23:0] pos_end;
    logic [23:0] mlen;
    logic [23:0] mpos;
  } tracker_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type_i;
  logic [12:0] frames_i;
  logic [1:0]  mode_in_i;
  logic [2:0]  selected_in_i;
  logic [2:0]  slot_sel_i;
  logic        active_in_i;
  logic        repeat_in_i;
  logic [23:0] cur_in_i;
  logic [23:0] start_in_i;
  logic [23:0] end_in_i;
  logic [23:0] master_len_in_i;
  logic [23:0] master_pos_in_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i;
  logic        result_valid_o;
  logic [23:0] cur_out_o;
  logic [23:0] start_out_o;
  logic [23:0] end_out_o;
  logic        active_out_o;
  logic        repeat_out_o;
  logic [23:0] master_pos_out_o;
  logic [23:0] master_len_out_o;
  logic [1:0]  mode_out_o;
  logic        buffer_full_o;

  // Tracked copy of the block's state.
  logic [23:0] trk_cur [NUM_SLOTS];
  logic [23:0] trk_start [NUM_SLOTS];
  logic [23:0] trk_end [NUM_SLOTS];
  logic        trk_active [NUM_SLOTS];
  logic        trk_repeat [NUM_SLOTS];
  logic [23:0] trk_master_pos;
  logic [23:0] trk_master_len;
  mode_e       trk_mode;
  logic [2:0]  trk_selected;
  logic [23:0] trk_limit;

  res_t expected_reports[$];
  int   errors;
  int   items_sent;
  int   sender_idle_pct;

  loop_track_position_tracker_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .frames_i         (frames_i),
    .mode_in_i        (mode_in_i),
    .selected_in_i    (selected_in_i),
    .slot_sel_i       (slot_sel_i),
    .active_in_i      (active_in_i),
    .repeat_in_i      (repeat_in_i),
    .cur_in_i         (cur_in_i),
    .start_in_i       (start_in_i),
    .end_in_i         (end_in_i),
    .master_len_in_i  (master_len_in_i),
    .master_pos_in_i  (master_pos_in_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .cur_out_o        (cur_out_o),
    .start_out_o      (start_out_o),
    .end_out_o        (end_out_o),
    .active_out_o     (active_out_o),
    .repeat_out_o     (repeat_out_o),
    .master_pos_out_o (master_pos_out_o),
    .master_len_out_o (master_len_out_o),
    .mode_out_o       (mode_out_o),
    .buffer_full_o    (buffer_full_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one request to the tracked state and return the report it should produce.
  function automatic res_t track_positions(input tracker_req_t r);
    res_t        rep;
    logic [2:0]  show;
    logic [24:0] sum;
    rep = '0;
    show = trk_selected;
    case (r.kind)
      REQ_ADVANCE: begin
        if (trk_mode != MODE_PASSTHROUGH) begin
          sum = 25'(trk_master_pos) + 25'(r.frames);
          trk_master_pos = (sum > 25'(trk_limit)) ? trk_limit : sum[23:0];
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!trk_active[i]) continue;
            sum = 25'(trk_cur[i]) + 25'(r.frames);
            if (3'(i) == trk_selected &&
                (trk_mode == MODE_RECORDING || trk_mode == MODE_OVERDUBBING)) begin
              // The slot being recorded stops at the limit and drops back to playback.
              if (sum > 25'(trk_limit)) begin
                sum = 25'(trk_limit);
                trk_mode = MODE_PLAYBACK;
                rep.full = 1'b1;
              end
              trk_cur[i] = sum[23:0];
              if (trk_cur[i] > trk_end[i]) trk_end[i] = trk_cur[i];
              if (trk_end[i] > trk_master_len) trk_master_len = trk_end[i];
            end else begin
              if (sum > 25'hFFFFFF) sum = 25'hFFFFFF;
              if (trk_repeat[i] && sum > 25'(trk_end[i])) sum = 25'(trk_start[i]);
              if (trk_master_pos > trk_master_len) begin
                sum = trk_repeat[i] ? 25'(trk_start[i]) : '0;
              end
              trk_cur[i] = sum[23:0];
            end
          end
          if (trk_mode == MODE_PLAYBACK && trk_master_pos > trk_master_len) begin
            trk_master_pos = '0;
          end
        end
      end
      REQ_SET_CTRL: begin
        trk_mode = r.mode;
        trk_selected = r.selected;
        trk_master_len = r.mlen;
        trk_master_pos = r.mpos;
        show = r.selected;
      end
      REQ_WRITE_SLOT: begin
        trk_active[r.slot] = r.active;
        trk_repeat[r.slot] = r.rpt;
        trk_cur[r.slot] = r.pos_cur;
        trk_start[r.slot] = r.pos_start;
        trk_end[r.slot] = r.pos_end;
        show = r.slot;
      end
      default: begin
        show = r.slot;
      end
    endcase
    rep.cur = trk_cur[show];
    rep.start = trk_start[show];
    rep.fin = trk_end[show];
    rep.active = trk_active[show];
    rep.rpt = trk_repeat[show];
    rep.master_pos = trk_master_pos;
    rep.master_len = trk_master_len;
    rep.mode = trk_mode;
    return rep;
  endfunction

  // Positions are mostly small so that ends, lengths and limits interact.
  function automatic logic [23:0] pick_pos();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 24'($urandom_range(20000));
    if (roll < 85) return 24'hFFFFFF - 24'($urandom_range(8191));
    return 24'($urandom());
  endfunction

  function automatic tracker_req_t noise_request();
    tracker_req_t r;
    r.kind = req_e'($urandom_range(3));
    r.frames = 13'($urandom_range(4096));
    r.mode = mode_e'($urandom_range(3));
    r.selected = 3'($urandom_range(7));
    r.slot = 3'($urandom_range(7));
    r.active = 1'($urandom_range(1));
    r.rpt = 1'($urandom_range(1));
    r.pos_cur = 24'($urandom());
    r.pos_start = 24'($urandom());
    r.pos_end = 24'($urandom());
    r.mlen = 24'($urandom());
    r.mpos = 24'($urandom());
    return r;
  endfunction

  // Offer one request, wait for its transfer and record the expected report.
  task automatic issue_request(input tracker_req_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= r.kind;
    frames_i <= r.frames;
    mode_in_i <= r.mode;
    selected_in_i <= r.selected;
    slot_sel_i <= r.slot;
    active_in_i <= r.active;
    repeat_in_i <= r.rpt;
    cur_in_i <= r.pos_cur;
    start_in_i <= r.pos_start;
    end_in_i <= r.pos_end;
    master_len_in_i <= r.mlen;
    master_pos_in_i <= r.mpos;
    do @(posedge clk_i); while (busy);
    expected_reports.push_back(track_positions(r));
    items_sent++;
  endtask

  task automatic send_advance(input logic [12:0] frames);
    tracker_req_t r;
    r = noise_request();
    r.kind = REQ_ADVANCE;
    r.frames = frames;
    issue_request(r);
  endtask

  task automatic send_set_ctrl(input mode_e mode, input logic [2:0] sel,
                               input logic [23:0] mlen, input logic [23:0] mpos);
    tracker_req_t r;
    r = noise_request();
    r.kind = REQ_SET_CTRL;
    r.mode = mode;
    r.selected = sel;
    r.mlen = mlen;
    r.mpos = mpos;
    issue_request(r);
  endtask

  task automatic send_write(input logic [2:0] slot, input logic active, input logic rpt,
                            input logic [23:0] cur, input logic [23:0] first,
                            input logic [23:0] last);
    tracker_req_t r;
    r = noise_request();
    r.kind = REQ_WRITE_SLOT;
    r.slot = slot;
    r.active = active;
    r.rpt = rpt;
    r.pos_cur = cur;
    r.pos_start = first;
    r.pos_end = last;
    issue_request(r);
  endtask

  task automatic send_read(input logic [2:0] slot);
    tracker_req_t r;
    r = noise_request();
    r.kind = REQ_READ_SLOT;
    r.slot = slot;
    issue_request(r);
  endtask

  // Hold the sender off until every outstanding report has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // The limit is only changed while the block is idle.
  task automatic write_sample_limit(input logic [23:0] value);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    trk_limit = value;
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every strobed report is compared with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: report with nothing expected, expected none, got cur %0h pos %0h",
                 $time, cur_out_o, master_pos_out_o);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("cur_out", want.cur, cur_out_o);
        check_field("start_out", want.start, start_out_o);
        check_field("end_out", want.fin, end_out_o);
        check_field("active_out", 24'(want.active), 24'(active_out_o));
        check_field("repeat_out", 24'(want.rpt), 24'(repeat_out_o));
        check_field("master_pos_out", want.master_pos, master_pos_out_o);
        check_field("master_len_out", want.master_len, master_len_out_o);
        check_field("mode_out", 24'(want.mode), 24'(mode_out_o));
        check_field("buffer_full", 24'(want.full), 24'(buffer_full_o));
      end
    end
  end

  task automatic test_reset_values();
    send_read(3'd0);
    send_read(3'd7);
  endtask

  // Advances in passthrough leave every slot and the master alone.
  task automatic test_passthrough();
    send_write(3'd0, 1'b1, 1'b0, 24'd100, 24'd0, 24'd500);
    send_advance(13'd4096);
  endtask

  task automatic test_record_clamp();
    write_sample_limit(24'd10000);
    send_write(3'd1, 1'b1, 1'b0, 24'd9000, 24'd0, 24'd9000);
    send_set_ctrl(MODE_RECORDING, 3'd1, 24'd100, 24'd9500);
    send_advance(13'd4096);
    send_read(3'd1);
  endtask

  // A zero limit clamps the overdubbed slot even on an advance of zero frames.
  task automatic test_overdub_zero_limit();
    write_sample_limit(24'd0);
    send_set_ctrl(MODE_OVERDUBBING, 3'd1, 24'd0, 24'd0);
    send_advance(13'd0);
  endtask

  task automatic test_unselected_saturation();
    write_sample_limit(24'hFFFFFF);
    send_write(3'd2, 1'b1, 1'b0, 24'hFFFFF0, 24'd0, 24'd0);
    send_set_ctrl(MODE_PLAYBACK, 3'd2, 24'hFFFFFF, 24'd0);
    send_advance(13'd4096);
  endtask

  task automatic test_repeat_wrap();
    send_write(3'd3, 1'b1, 1'b1, 24'd150, 24'd100, 24'd200);
    send_set_ctrl(MODE_PLAYBACK, 3'd3, 24'hFFFFFF, 24'd0);
    send_advance(13'd100);
  endtask

  // The master passing its length restarts every active slot and itself.
  task automatic test_master_restart();
    send_set_ctrl(MODE_PLAYBACK, 3'd3, 24'd1000, 24'd900);
    send_advance(13'd200);
  endtask

  task automatic test_field_extremes();
    send_write(3'd7, 1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_read(3'd7);
    send_set_ctrl(MODE_OVERDUBBING, 3'd7, 24'hFFFFFF, 24'hFFFFFF);
    send_advance(13'd4096);
  endtask

  // One loop take: load some slots, arm a mode, then run a burst of advances and reads.
  task automatic run_take();
    int unsigned roll;
    mode_e       mode;
    if ($urandom_range(99) < 8) write_sample_limit(24'($urandom_range(1000, 40000)));
    repeat ($urandom_range(1, 3)) begin
      send_write(3'($urandom_range(7)), 1'($urandom_range(99) < 75),
                 1'($urandom_range(1)), pick_pos(), pick_pos(), pick_pos());
    end
    roll = $urandom_range(99);
    if (roll < 35) mode = MODE_RECORDING;
    else if (roll < 55) mode = MODE_OVERDUBBING;
    else if (roll < 90) mode = MODE_PLAYBACK;
    else mode = MODE_PASSTHROUGH;
    send_set_ctrl(mode, 3'($urandom_range(7)), pick_pos(), pick_pos());
    repeat ($urandom_range(3, 12)) begin
      roll = $urandom_range(99);
      if (roll < 12) send_read(3'($urandom_range(7)));
      else if (roll < 20) issue_request(noise_request());
      else if (roll < 25) send_advance(($urandom_range(1)) ? 13'd4096 : 13'd0);
      else send_advance(13'($urandom_range(64, 2048)));
    end
  endtask

  task automatic test_random_phases();
    int          pct [4];
    logic [23:0] lim [4];
    int          target;
    pct = '{0, 77, 0, 19};
    lim = '{24'hFFFFFF, 24'd25000, 24'($urandom_range(2000, 40000)), 24'($urandom())};
    for (int p = 0; p < 4; p++) begin
      write_sample_limit(lim[p]);
      sender_idle_pct = pct[p];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_take();
    end
  endtask

  initial begin
    int waited;
    waited = 0;
    errors = 0;
    items_sent = 0;
    sender_idle_pct = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      trk_cur[i] = '0;
      trk_start[i] = '0;
      trk_end[i] = '0;
      trk_active[i] = 1'b0;
      trk_repeat[i] = 1'b0;
    end
    trk_master_pos = '0;
    trk_master_len = '0;
    trk_mode = MODE_PASSTHROUGH;
    trk_selected = '0;
    trk_limit = 24'hFFFFFF;

    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = REQ_ADVANCE;
    frames_i = '0;
    mode_in_i = MODE_PASSTHROUGH;
    selected_in_i = '0;
    slot_sel_i = '0;
    active_in_i = 1'b0;
    repeat_in_i = 1'b0;
    cur_in_i = '0;
    start_in_i = '0;
    end_in_i = '0;
    master_len_in_i = '0;
    master_pos_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_passthrough();
    test_record_clamp();
    test_overdub_zero_limit();
    test_unselected_saturation();
    test_repeat_wrap();
    test_master_restart();
    test_field_extremes();
    test_random_phases();

    // Let the last reports come back, then allow for stragglers.
    start <= 1'b0;
    while (expected_reports.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $display("%0t: reports missing, expected 0 outstanding, got %0d",
               $time, expected_reports.size());
      errors += expected_reports.size();
    end
    if (errors == 0) begin
      $display("tb_loop_track_position_tracker_unit: done, clean");
    end else begin
      $display("tb_loop_track_position_tracker_unit: done, errors");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("tb_loop_track_position_tracker_unit: done, errors");
    $finish;
  end

endmodule
